[hw/rtl/top_k_ranked_table_core_assert.svh]
// Assertion macros for the ranked table core checkers.
`ifndef TOP_K_RANKED_TABLE_CORE_ASSERT_SVH
`define TOP_K_RANKED_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TKR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tkr_pkg.sv]
// Package: shared types, constants and the rank compare for the ranked table.
package tkr_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int TAG_W     = 32;
    localparam int SCORE_W   = 32;
    localparam int DUR_W     = 32;
    localparam int RANK_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int INDEX_W   = 3;

    typedef enum logic [0:0] {
        KIND_SUBMIT = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
        logic [DUR_W-1:0]   duration;
    } entry_t;

    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  placed_rank;
        logic [COUNT_W-1:0] entry_count;
        logic               entry_valid;
        entry_t             entry;
    } result_t;

    // cand ranks strictly ahead of e: higher score, or equal score and shorter duration
    function automatic logic ranks_ahead(entry_t cand, entry_t e);
        return (cand.score > e.score) ||
               ((cand.score == e.score) && (cand.duration < e.duration));
    endfunction

endpackage

[hw/rtl/tkr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module tkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tkr_ctrl.sv]
// Sequencer: scans the table bottom-up, shifts entries down and writes the new one.
module tkr_ctrl #(
    parameter int DEPTH = tkr_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [tkr_pkg::TAG_W-1:0]     player_tag,
    input  logic [tkr_pkg::SCORE_W-1:0]   score,
    input  logic [tkr_pkg::DUR_W-1:0]     duration,
    input  logic [tkr_pkg::INDEX_W-1:0]   read_index,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output tkr_pkg::entry_t               mem_wdata,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  tkr_pkg::entry_t               mem_rdata,
    output logic                          done,
    output tkr_pkg::result_t              result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CHKFULL = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_PLACE   = 5'b01000,
        ST_RDOUT   = 5'b10000
    } state_t;

    state_t           state_reg,  state_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [AW-1:0]    k_reg,      k_next;
    tkr_pkg::entry_t  item_reg,   item_next;
    logic             valid_reg,  valid_next;
    logic             done_reg,   done_next;
    tkr_pkg::result_t res_reg,    res_next;

    tkr_pkg::entry_t  in_entry;
    logic             is_full;
    logic [CW-1:0]    count_after;
    logic [AW-1:0]    wpos;

    assign in_entry    = '{tag: player_tag, score: score, duration: duration};
    assign is_full     = (count_reg == CW'(DEPTH));
    assign count_after = is_full ? count_reg : count_reg + CW'(1);
    assign wpos        = k_reg + AW'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        item_next  = item_reg;
        valid_next = valid_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = item_reg;
        mem_raddr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == tkr_pkg::KIND_READ)
                    begin
                        valid_next = (32'(read_index) < 32'(count_reg));
                        mem_raddr  = AW'(read_index);
                        state_next = ST_RDOUT;
                    end
                    else
                    begin
                        item_next = in_entry;
                        if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = in_entry;
                            count_next = CW'(1);
                            res_next   = '{accepted: 1'b1, placed_rank: '0,
                                           entry_count: tkr_pkg::COUNT_W'(1),
                                           entry_valid: 1'b0, entry: '0};
                            done_next  = 1'b1;
                        end
                        else if (is_full)
                        begin
                            mem_raddr  = AW'(DEPTH - 1);
                            state_next = ST_CHKFULL;
                        end
                        else
                        begin
                            mem_raddr  = AW'(count_reg - CW'(1));
                            k_next     = AW'(count_reg - CW'(1));
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_CHKFULL:
            begin
                if (item_reg.score > mem_rdata.score)
                begin
                    mem_raddr  = AW'(DEPTH - 2);
                    k_next     = AW'(DEPTH - 2);
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_next   = '{accepted: 1'b0, placed_rank: '0,
                                   entry_count: tkr_pkg::COUNT_W'(count_reg),
                                   entry_valid: 1'b0, entry: '0};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                mem_we    = 1'b1;
                mem_waddr = wpos;
                if (tkr_pkg::ranks_ahead(item_reg, mem_rdata))
                begin
                    mem_wdata = mem_rdata;
                    if (k_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        mem_raddr = k_reg - AW'(1);
                        k_next    = k_reg - AW'(1);
                    end
                end
                else
                begin
                    mem_wdata  = item_reg;
                    count_next = count_after;
                    res_next   = '{accepted: 1'b1,
                                   placed_rank: tkr_pkg::RANK_W'(wpos),
                                   entry_count: tkr_pkg::COUNT_W'(count_after),
                                   entry_valid: 1'b0, entry: '0};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = item_reg;
                count_next = count_after;
                res_next   = '{accepted: 1'b1, placed_rank: '0,
                               entry_count: tkr_pkg::COUNT_W'(count_after),
                               entry_valid: 1'b0, entry: '0};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_RDOUT:
            begin
                res_next   = '{accepted: 1'b0, placed_rank: '0,
                               entry_count: tkr_pkg::COUNT_W'(count_reg),
                               entry_valid: valid_reg,
                               entry: valid_reg ? mem_rdata : '0};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        item_reg  <= item_next;
        valid_reg <= valid_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

[hw/rtl/top_k_ranked_table_core.sv]
// Top level of the ranked table: up to DEPTH (tag, score, duration) entries.
//
// Command channel: an item transfers on a rising edge with start high and busy low.
// kind selects submit (insert in rank order) or read (entry at read_index and count).
// Result channel: done is high for one cycle with the result fields; the receiver
// cannot stall, so every result must be taken in that cycle.
// Entries live in one RAM with a registered read; the sequencer walks the
// table from the last held entry upward, one entry per cycle, moving each entry
// that ranks behind the submit down by one slot.
// A submit into an empty table is written straight to slot zero; on a full
// table it is dropped unless its score is higher than that of the last entry,
// so an equal score is dropped whatever its duration.
// busy is low again in the cycle done is shown, so the next transfer may overlap it.
// Reset empties the table (count zero) and returns the sequencer to idle; no
// clearing pass is needed since only entries below the count are ever read.
module top_k_ranked_table_core #(
    parameter int DEPTH = tkr_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [tkr_pkg::TAG_W-1:0]    player_tag,
    input  logic [tkr_pkg::SCORE_W-1:0]  score,
    input  logic [tkr_pkg::DUR_W-1:0]    duration,
    input  logic [tkr_pkg::INDEX_W-1:0]  read_index,
    output logic                         done,
    output logic                         accepted,
    output logic [tkr_pkg::RANK_W-1:0]   placed_rank,
    output logic [tkr_pkg::COUNT_W-1:0]  entry_count,
    output logic                         entry_valid,
    output logic [tkr_pkg::TAG_W-1:0]    entry_tag,
    output logic [tkr_pkg::SCORE_W-1:0]  entry_score,
    output logic [tkr_pkg::DUR_W-1:0]    entry_duration
);

    localparam int AW = $clog2(DEPTH);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    tkr_pkg::entry_t  mem_wdata;
    logic [AW-1:0]    mem_raddr;
    tkr_pkg::entry_t  mem_rdata;
    tkr_pkg::result_t result;

    tkr_ram #(
        .WIDTH ($bits(tkr_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tkr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .player_tag (player_tag),
        .score      (score),
        .duration   (duration),
        .read_index (read_index),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .done       (done),
        .result     (result)
    );

    assign accepted       = result.accepted;
    assign placed_rank    = result.placed_rank;
    assign entry_count    = result.entry_count;
    assign entry_valid    = result.entry_valid;
    assign entry_tag      = result.entry.tag;
    assign entry_score    = result.entry.score;
    assign entry_duration = result.entry.duration;

endmodule

[hw/rtl/tkr_checker.sv]
// Port-level checker for the ranked table core, bound to the top level.
`include "top_k_ranked_table_core_assert.svh"

module tkr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         accepted,
    input logic [tkr_pkg::RANK_W-1:0]   placed_rank,
    input logic                         entry_valid,
    input logic [tkr_pkg::TAG_W-1:0]    entry_tag,
    input logic [tkr_pkg::SCORE_W-1:0]  entry_score,
    input logic [tkr_pkg::DUR_W-1:0]    entry_duration
);

    `TKR_ASSERT_NEXT(a_transfer_progress, clk, rst_n, start && !busy, busy || done,
        "transfer neither started work nor produced a result")

    `TKR_ASSERT_IMPL(a_submit_not_read, clk, rst_n, done && accepted, !entry_valid,
        "result flags both an accepted submit and a valid read")

    `TKR_ASSERT_IMPL(a_drop_rank_zero, clk, rst_n, done && !accepted, placed_rank == '0,
        "rank reported without an accepted submit")

    `TKR_ASSERT_IMPL(a_invalid_zero, clk, rst_n, done && !entry_valid,
        entry_tag == '0 && entry_score == '0 && entry_duration == '0,
        "entry fields nonzero without a valid read")

endmodule

bind top_k_ranked_table_core tkr_checker u_tkr_checker (.*);
